// File: design/u8atc_pkg.sv
// shared types, codes and the accent table of the text converter
package u8atc_pkg;

    localparam logic [7:0] LF_CODE    = 8'h0A;
    localparam logic [7:0] CR_CODE    = 8'h0D;
    localparam logic [7:0] LEAD_CODE  = 8'hC3;
    localparam logic [7:0] ACCENT_ESC = 8'h16;

    localparam int QUEUE_DEPTH = 4;

    // position of a beat within a three-beat expansion
    typedef logic [1:0] t_beat_idx;
    localparam t_beat_idx BEAT_FIRST = 2'd0;
    localparam t_beat_idx BEAT_LAST  = 2'd2;

    // one queued job: a single byte or an escape triple
    typedef struct packed {
        logic       triple;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_entry;

    // head of the queue as seen by the back end
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
        logic [7:0] letter;
    } t_accent;

    function automatic t_accent accent_lookup(input logic [7:0] b);
        t_accent r;
        r = '0;
        r.hit = 1'b1;
        case (b)
            8'hA2: begin r.code = 8'h43; r.letter = 8'h61; end
            8'hA0: begin r.code = 8'h41; r.letter = 8'h61; end
            8'hAB: begin r.code = 8'h48; r.letter = 8'h65; end
            8'hAA: begin r.code = 8'h43; r.letter = 8'h65; end
            8'hA9: begin r.code = 8'h42; r.letter = 8'h65; end
            8'hA8: begin r.code = 8'h41; r.letter = 8'h65; end
            8'hAF: begin r.code = 8'h48; r.letter = 8'h69; end
            8'hAE: begin r.code = 8'h43; r.letter = 8'h69; end
            8'hB6: begin r.code = 8'h48; r.letter = 8'h6F; end
            8'hB4: begin r.code = 8'h43; r.letter = 8'h6F; end
            8'hBC: begin r.code = 8'h48; r.letter = 8'h75; end
            8'hBB: begin r.code = 8'h43; r.letter = 8'h75; end
            8'hB9: begin r.code = 8'h41; r.letter = 8'h75; end
            8'hA7: begin r.code = 8'h4B; r.letter = 8'h63; end
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: design/u8atc_front.sv
// front end: accepts input beats, tracks the flags and builds queue entries
module u8atc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_eot,
    output logic              o_push,
    output u8atc_pkg::t_entry o_entry
);
    import u8atc_pkg::*;

    logic    r_line_end, n_line_end;
    logic    r_accent, n_accent;
    t_accent lk;

    assign lk = accent_lookup(i_byte);

    always_comb begin
        n_line_end = r_line_end;
        n_accent   = r_accent;
        o_push     = 1'b0;
        o_entry    = '0;
        if (i_accept) begin
            if (i_byte == LF_CODE || i_byte == CR_CODE) begin
                if (!r_line_end) begin
                    o_push     = 1'b1;
                    o_entry.b0 = CR_CODE;
                    n_line_end = 1'b1;
                end
            end else if (i_byte == LEAD_CODE) begin
                n_accent = 1'b1;
            end else if (r_accent) begin
                n_accent       = 1'b0;
                o_push         = 1'b1;
                o_entry.triple = 1'b1;
                o_entry.b0     = lk.hit ? ACCENT_ESC : 8'h00;
                o_entry.b1     = lk.code;
                o_entry.b2     = lk.letter;
            end else begin
                o_push     = 1'b1;
                o_entry.b0 = i_byte;
                n_line_end = 1'b0;
            end
            if (i_eot) begin
                n_line_end = 1'b0;
                n_accent   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_end <= 1'b0;
            r_accent   <= 1'b0;
        end else begin
            r_line_end <= n_line_end;
            r_accent   <= n_accent;
        end
    end

endmodule

// File: design/u8atc_queue.sv
// short queue of entries between front and back end
module u8atc_queue #(
    parameter int DEPTH = u8atc_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u8atc_pkg::t_entry i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output u8atc_pkg::t_head  o_head
);
    import u8atc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full       = (r_cnt == CNT_FULL);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.entry = r_mem[r_rd];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: design/u8atc_back.sv
// back end: expands queue entries into output beats through an output register
module u8atc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  u8atc_pkg::t_head i_head,
    output logic             o_pop,
    output logic             o_valid,
    output logic [7:0]       o_data,
    output logic             o_last,
    input  logic             i_ready
);
    import u8atc_pkg::*;

    t_beat_idx  r_idx, n_idx;
    logic       r_valid;
    logic [7:0] r_data, n_data;
    logic       r_last, n_last;
    logic       load;

    assign load = i_head.valid && (!r_valid || i_ready);

    always_comb begin
        n_idx  = r_idx;
        n_data = i_head.entry.b0;
        n_last = 1'b1;
        o_pop  = 1'b0;
        if (i_head.entry.triple) begin
            case (r_idx)
                BEAT_FIRST: n_data = i_head.entry.b0;
                BEAT_LAST:  n_data = i_head.entry.b2;
                default:    n_data = i_head.entry.b1;
            endcase
            n_last = (r_idx == BEAT_LAST);
        end
        if (load) begin
            if (n_last) begin
                o_pop = 1'b1;
                n_idx = BEAT_FIRST;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= BEAT_FIRST;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
            r_last <= n_last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx == BEAT_FIRST || r_idx == 2'd1 || r_idx == BEAT_LAST)
        else $error("beat index out of range");

    a_mid_triple: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != BEAT_FIRST) |-> (i_head.valid && i_head.entry.triple))
        else $error("expansion in progress without a triple at the queue head");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !n_last) |=> (r_idx == $past(r_idx) + 2'd1))
        else $error("beat index did not advance");

endmodule

// File: design/utf8_accent_text_converter.sv
// top level of the utf-8 accent text converter
// Converts a text byte stream one input beat at a time. LF becomes CR, CR
// passes, and further line ends are dropped until a plain byte follows. A
// 0xC3 lead byte is swallowed; the next byte that is not a line end or lead
// is sent as three beats 0x16, accent code, base letter (three zero beats if
// the byte is not in the table). tlast on the input marks end of text and
// clears both flags after that byte; tlast on the output marks the final beat
// caused by one input. An input beat is taken every cycle while the queue
// between the classifying front end and the expanding back end has room; the
// back end delivers one output beat per cycle while the output is ready, so
// plain text runs at one beat per cycle and each accent costs three output
// beats. Input goes through the queue write, then the output register.
module utf8_accent_text_converter #(
    parameter int QUEUE_DEPTH = u8atc_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // in_byte [7:0]
    input  logic       i_s_axis_tlast,   // end_of_text
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // out_byte [7:0]
    output logic       o_m_axis_tlast    // last_of_run
);
    import u8atc_pkg::*;

    logic   accept;
    logic   push, pop, full;
    t_entry entry;
    t_head  head;

    // input is held off only while the queue is full
    assign o_s_axis_tready = !full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // classification and flag tracking
    u8atc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_eot    (i_s_axis_tlast),
        .o_push   (push),
        .o_entry  (entry)
    );

    // decoupling queue, one entry per input beat that gives output
    u8atc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    // expansion into output beats
    u8atc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast),
        .i_ready (i_m_axis_tready)
    );

endmodule
